/* design/timer_queue_expiry_engine_macros.svh */
// Assertion helpers for the timer queue expiry engine
`ifndef TIMER_QUEUE_EXPIRY_ENGINE_MACROS_SVH
`define TIMER_QUEUE_EXPIRY_ENGINE_MACROS_SVH
`ifndef SYNTH
`define TQE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TQE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/tqe_pkg.sv */
package tqe_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int TIME_BITS   = 48;
	localparam int SLOT_BITS   = $clog2(TIMER_SLOTS);

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED   = 3'd4;
	localparam logic [2:0] ST_NONE_DUE  = 3'd5;

	typedef struct packed {
		logic [1:0]           mode;
		logic [TIME_BITS-1:0] expire_time;
		logic [31:0]          repeat_interval;
		logic [SLOT_BITS-1:0] cancel_slot;
		logic [7:0]           cancel_generation;
		logic [TIME_BITS-1:0] now_time;
	} tqe_req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [SLOT_BITS-1:0] timer_slot;
		logic [7:0]           timer_generation;
		logic                 earliest_changed;
		logic [TIME_BITS-1:0] next_expiry;
		logic                 next_valid;
		logic                 last_result;
	} tqe_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_ADD_RD,
		S_ADD_WR,
		S_CAN_RD,
		S_CAN_CHK,
		S_TICK_SCAN,
		S_TICK_UPD,
		S_NEXT_SCAN,
		S_EMIT_RD,
		S_EMIT_SHOW
	} tqe_state_t;

	typedef enum logic [1:0] {
		SCAN_ADD,
		SCAN_PICK,
		SCAN_NEXT
	} tqe_scan_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_CANCEL,
		RD_FREE
	} tqe_rdsel_t;

	typedef struct packed {
		logic       load;
		logic       scan;
		tqe_scan_t  kind;
		tqe_rdsel_t rd_sel;
		logic       add_full;
		logic       add_wr;
		logic       can_chk;
		logic       tick_upd;
		logic       emit_adv;
	} tqe_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pick_found;
		logic free_found;
		logic emit_last;
	} tqe_stat_t;

endpackage

/* design/tqe_ctrl.sv */
module tqe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_mode,
	input  logic             rsp_ready,
	input  tqe_pkg::tqe_stat_t stat,
	output tqe_pkg::tqe_cmd_t  cmd,
	output logic             req_ready,
	output logic             rsp_valid
);
	import tqe_pkg::*;

	tqe_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.kind  = SCAN_NEXT;
		cmd.rd_sel = RD_SCAN;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					priority if (req_mode == MODE_ADD) state_d = S_ADD_SCAN;
					else if (req_mode == MODE_CANCEL) state_d = S_CAN_RD;
					else if (req_mode == MODE_TICK) state_d = S_TICK_SCAN;
					else state_d = S_IDLE;
				end
			end
			S_ADD_SCAN: begin
				cmd.scan = 1'b1;
				cmd.kind = SCAN_ADD;
				if (stat.scan_done) state_d = S_ADD_RD;
			end
			S_ADD_RD: begin
				cmd.rd_sel = RD_FREE;
				if (stat.free_found) begin
					state_d = S_ADD_WR;
				end else begin
					cmd.add_full = 1'b1;
					state_d = S_NEXT_SCAN;
				end
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d = S_NEXT_SCAN;
			end
			S_CAN_RD: begin
				cmd.rd_sel = RD_CANCEL;
				state_d = S_CAN_CHK;
			end
			S_CAN_CHK: begin
				cmd.can_chk = 1'b1;
				state_d = S_NEXT_SCAN;
			end
			S_TICK_SCAN: begin
				cmd.scan = 1'b1;
				cmd.kind = SCAN_PICK;
				if (stat.scan_done) state_d = S_TICK_UPD;
			end
			S_TICK_UPD: begin
				cmd.tick_upd = 1'b1;
				state_d = stat.pick_found ? S_TICK_SCAN : S_NEXT_SCAN;
			end
			S_NEXT_SCAN: begin
				cmd.scan = 1'b1;
				cmd.kind = SCAN_NEXT;
				if (stat.scan_done) state_d = S_EMIT_RD;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_SHOW;
			end
			S_EMIT_SHOW: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.emit_adv = 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* design/tqe_datapath.sv */
module tqe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tqe_pkg::tqe_req_t req,
	input  tqe_pkg::tqe_cmd_t cmd,
	output tqe_pkg::tqe_stat_t stat,
	output tqe_pkg::tqe_rsp_t rsp
);
	import tqe_pkg::*;

	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	typedef struct packed {
		logic [2:0]    status;
		logic [IW-1:0] slot;
		logic [7:0]    gen;
		logic          chg;
	} ent_t;

	tqe_req_t req_q;
	logic [TIME_BITS-1:0] now_q, when_q;

	logic [TIME_BITS-1:0] exp_mem [TIMER_SLOTS];
	logic [31:0]          per_mem [TIMER_SLOTS];
	logic [7:0]           gen_mem [TIMER_SLOTS];
	ent_t                 buf_mem [TIMER_SLOTS];

	logic [TIME_BITS-1:0] exp_rd;
	logic [31:0]          per_rd;
	logic [7:0]           gen_rd;
	ent_t                 buf_rd;

	logic [TIMER_SLOTS-1:0] valid_q, written_q, due_q;
	logic [IW-1:0] rd_addr, rd_addr_s1;
	logic [CW-1:0] ix_q, cnt_q;
	logic [IW-1:0] k_q;
	logic          first_q;

	logic                 acc_any_q;
	logic [TIME_BITS-1:0] acc_min_q;
	logic [IW-1:0]        acc_slot_q;
	logic [7:0]           acc_gen_q;
	logic [31:0]          acc_per_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_slot_q;

	logic                 proc, first, v, due_now, cand, any_c, take, nf, can_hit;
	logic [7:0]           g;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] rearm;
	logic [8:0]           cs9;

	logic          mem_we_exp, mem_we_all;
	logic [IW-1:0] mem_wa;
	logic [TIME_BITS-1:0] mem_wd_exp;
	logic [7:0]    gen_new;
	logic          buf_we;
	logic [IW-1:0] buf_wa;
	ent_t          buf_wd;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_CANCEL: rd_addr = IW'(req_q.cancel_slot);
			RD_FREE:   rd_addr = free_slot_q;
			default:   rd_addr = ix_q[IW-1:0];
		endcase
	end

	assign proc    = cmd.scan && (ix_q != '0);
	assign first   = ix_q == CW'(1);
	assign v       = valid_q[rd_addr_s1];
	assign g       = written_q[rd_addr_s1] ? gen_rd : 8'd0;
	assign due_now = v && (exp_rd <= now_q);
	assign cand    = (cmd.kind == SCAN_PICK) ? (first_q ? due_now : due_q[rd_addr_s1]) : v;
	assign any_c   = first ? 1'b0 : acc_any_q;
	assign take    = cand && (!any_c || (exp_rd < acc_min_q));
	assign nf      = first ? 1'b0 : free_found_q;

	assign cs9     = 9'(req_q.cancel_slot);
	assign can_hit = (cs9 < 9'(TIMER_SLOTS)) && v && (g == req_q.cancel_generation);

	assign sum     = {1'b0, now_q} + (TIME_BITS + 1)'(acc_per_q);
	assign rearm   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	assign gen_new = g + 8'd1;

	always_comb begin
		mem_we_exp = 1'b0;
		mem_we_all = 1'b0;
		mem_wa     = free_slot_q;
		mem_wd_exp = when_q;
		buf_we     = 1'b0;
		buf_wa     = '0;
		buf_wd     = '0;
		if (cmd.add_wr) begin
			mem_we_all    = 1'b1;
			buf_we        = 1'b1;
			buf_wd.status = ST_ADDED;
			buf_wd.slot   = free_slot_q;
			buf_wd.gen    = gen_new;
			buf_wd.chg    = !acc_any_q || (when_q < acc_min_q);
		end
		if (cmd.add_full) begin
			buf_we        = 1'b1;
			buf_wd.status = ST_FULL;
		end
		if (cmd.can_chk) begin
			buf_we        = 1'b1;
			buf_wd.status = can_hit ? ST_CANCELLED : ST_NOT_FOUND;
		end
		if (cmd.tick_upd) begin
			mem_wa     = acc_slot_q;
			mem_wd_exp = rearm;
			if (acc_any_q) begin
				mem_we_exp    = acc_per_q != 32'd0;
				buf_we        = 1'b1;
				buf_wa        = cnt_q[IW-1:0];
				buf_wd.status = ST_EXPIRED;
				buf_wd.slot   = acc_slot_q;
				buf_wd.gen    = acc_gen_q;
			end else if (cnt_q == '0) begin
				buf_we        = 1'b1;
				buf_wd.status = ST_NONE_DUE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we_all || mem_we_exp) exp_mem[mem_wa] <= mem_wd_exp;
		if (mem_we_all) begin
			per_mem[mem_wa] <= req_q.repeat_interval;
			gen_mem[mem_wa] <= gen_new;
		end
		if (buf_we) buf_mem[buf_wa] <= buf_wd;
		exp_rd     <= exp_mem[rd_addr];
		per_rd     <= per_mem[rd_addr];
		gen_rd     <= gen_mem[rd_addr];
		buf_rd     <= buf_mem[k_q];
		rd_addr_s1 <= rd_addr;
		if (cmd.load) begin
			req_q  <= req;
			now_q  <= TIME_BITS'(req.now_time);
			when_q <= TIME_BITS'(req.expire_time);
		end
		if (proc) begin
			if (take) begin
				acc_min_q  <= exp_rd;
				acc_slot_q <= rd_addr_s1;
				acc_gen_q  <= g;
				acc_per_q  <= per_rd;
			end
			if (!v && !nf) free_slot_q <= rd_addr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			written_q    <= '0;
			due_q        <= '0;
			ix_q         <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			first_q      <= 1'b0;
			acc_any_q    <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q   <= '0;
				k_q     <= '0;
				first_q <= 1'b1;
			end
			if (cmd.scan) begin
				ix_q <= (ix_q == CW'(TIMER_SLOTS)) ? '0 : ix_q + CW'(1);
				if (stat.scan_done && cmd.kind == SCAN_PICK) first_q <= 1'b0;
			end
			if (proc) begin
				acc_any_q    <= any_c | cand;
				free_found_q <= nf | !v;
				if (cmd.kind == SCAN_PICK && first_q) due_q[rd_addr_s1] <= due_now;
			end
			if (cmd.add_wr) begin
				valid_q[free_slot_q]   <= 1'b1;
				written_q[free_slot_q] <= 1'b1;
			end
			if (cmd.add_full || cmd.add_wr) cnt_q <= CW'(1);
			if (cmd.can_chk) begin
				cnt_q <= CW'(1);
				if (can_hit) valid_q[rd_addr_s1] <= 1'b0;
			end
			if (cmd.tick_upd) begin
				if (acc_any_q) begin
					cnt_q             <= cnt_q + CW'(1);
					due_q[acc_slot_q] <= 1'b0;
					if (acc_per_q == 32'd0) valid_q[acc_slot_q] <= 1'b0;
				end else if (cnt_q == '0) begin
					cnt_q <= CW'(1);
				end
			end
			if (cmd.emit_adv) k_q <= k_q + IW'(1);
		end
	end

	assign stat.scan_done  = cmd.scan && (ix_q == CW'(TIMER_SLOTS));
	assign stat.pick_found = acc_any_q;
	assign stat.free_found = free_found_q;
	assign stat.emit_last  = (CW'(k_q) + CW'(1)) == cnt_q;

	assign rsp.status           = buf_rd.status;
	assign rsp.timer_slot       = buf_rd.slot;
	assign rsp.timer_generation = buf_rd.gen;
	assign rsp.earliest_changed = buf_rd.chg;
	assign rsp.next_expiry      = acc_any_q ? acc_min_q : '0;
	assign rsp.next_valid       = acc_any_q;
	assign rsp.last_result      = stat.emit_last;

endmodule

/* design/timer_queue_expiry_engine.sv */
// Timer table of TIMER_SLOTS entries, one request beat at a time. Every pass
// walks the table one slot per cycle through the single read port of the
// expiry, period and tag memories. An add takes two passes, a cancel one
// pass, a tick (D+2) passes for D due timers, or two passes when none is
// due. Each result beat is read from the result buffer and then held until
// the response side is ready. A new request is taken only once the last
// result beat of the previous one is gone.
module timer_queue_expiry_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tqe_pkg::tqe_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tqe_pkg::tqe_rsp_t rsp
);
	import tqe_pkg::*;

`include "timer_queue_expiry_engine_macros.svh"

	tqe_cmd_t  cmd;
	tqe_stat_t stat;
	logic      rsp_end, req_drop;

	assign rsp_end  = rsp_valid && rsp_ready && rsp.last_result;
	assign req_drop = req_valid && req_ready && (req.mode == MODE_UNUSED);

	tqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid)
	);

	tqe_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	`TQE_ASSERT_IMPL(a_no_overlap, clk, arst_n, rsp_valid, !req_ready, "request taken mid item")
	`TQE_ASSERT_NEXT(a_last_frees, clk, arst_n, rsp_end, req_ready, "busy after last beat")
	`TQE_ASSERT_NEXT(a_mode3_drop, clk, arst_n, req_drop, req_ready, "unused mode not dropped")

endmodule
